/* rtl/hrcp_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hrcp_pkg
// Shared types, character codes and line positions for the hex record
// character parser.
// ----------------------------------------------------------------------------
package hrcp_pkg;

  localparam int RING_SLOTS_DEFAULT = 16;

  localparam int POS_W  = 10;
  localparam int WORD_W = 16;

  // ascii codes
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_SEVEN = 8'h37;
  localparam logic [7:0] CH_NINE  = 8'h39;

  // line positions
  localparam logic [POS_W-1:0] POS_START    = 10'd0;
  localparam logic [POS_W-1:0] POS_COUNT_HI = 10'd1;
  localparam logic [POS_W-1:0] POS_COUNT_LO = 10'd2;
  localparam logic [POS_W-1:0] POS_ADDR_0   = 10'd3;
  localparam logic [POS_W-1:0] POS_ADDR_1   = 10'd4;
  localparam logic [POS_W-1:0] POS_ADDR_2   = 10'd5;
  localparam logic [POS_W-1:0] POS_ADDR_3   = 10'd6;
  localparam logic [POS_W-1:0] POS_HDR_LAST = 10'd8;
  localparam logic [POS_W-1:0] POS_MAX      = 10'd1023;
  localparam logic [POS_W-1:0] HDR_CHARS    = 10'd9;

  // byte counts from this value on give a saturated line length
  localparam logic [WORD_W-1:0] COUNT_SAT = 16'd507;

  // position within a data word (position mod 4)
  localparam logic [1:0] DPH_LO_HI = 2'd1;
  localparam logic [1:0] DPH_LO_LO = 2'd2;
  localparam logic [1:0] DPH_HI_HI = 2'd3;
  localparam logic [1:0] DPH_HI_LO = 2'd0;

  typedef enum logic [1:0] {
    KIND_COUNT = 2'd0,
    KIND_ADDR  = 2'd1,
    KIND_DATA  = 2'd2
  } word_kind_t;

  typedef struct packed {
    logic [POS_W-1:0]  line_position;
    logic [POS_W-1:0]  line_length;
    logic [WORD_W-1:0] low_part;
    logic [WORD_W-1:0] high_part;
    logic [WORD_W-1:0] data_word_count;
  } line_state_t;

  typedef struct packed {
    logic              produced;
    logic [WORD_W-1:0] word;
    word_kind_t        kind;
    logic [WORD_W-1:0] count;
  } emit_t;

endpackage

/* rtl/hrcp_decode.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hrcp_decode
// Next-state and emitted word for one received character or restart.
// ----------------------------------------------------------------------------
module hrcp_decode (
  input  logic                 op,
  input  logic [7:0]           rx_char,
  input  hrcp_pkg::line_state_t cur,
  output hrcp_pkg::line_state_t nxt,
  output hrcp_pkg::emit_t      emit
);

  logic [7:0]                   nib;
  logic [hrcp_pkg::POS_W-1:0]   pos;
  logic [hrcp_pkg::WORD_W-1:0]  nib16;
  logic [hrcp_pkg::WORD_W-1:0]  nib_sh4;
  logic [hrcp_pkg::WORD_W-1:0]  sum;

  always_comb begin
    nxt  = cur;
    emit = '0;
    nib  = '0;
    pos  = cur.line_position;
    sum  = '0;

    if (cur.line_position == hrcp_pkg::POS_MAX) begin
      pos = hrcp_pkg::POS_MAX;
    end

    priority if (rx_char == hrcp_pkg::CH_COLON) begin
      pos = hrcp_pkg::POS_START;
    end else if (rx_char <= hrcp_pkg::CH_NINE) begin
      nib = rx_char - hrcp_pkg::CH_ZERO;
    end else begin
      nib = rx_char - hrcp_pkg::CH_SEVEN;
    end

    nib16   = {8'd0, nib};
    nib_sh4 = {4'd0, nib, 4'd0};

    unique case (pos)
      hrcp_pkg::POS_COUNT_HI: nxt.low_part = nib_sh4;
      hrcp_pkg::POS_COUNT_LO: begin
        nxt.low_part = cur.low_part + nib16;
        // 9 + 2*count, capped at the top line position
        if (nxt.low_part >= hrcp_pkg::COUNT_SAT) begin
          nxt.line_length = hrcp_pkg::POS_MAX;
        end else begin
          nxt.line_length = hrcp_pkg::HDR_CHARS + {nxt.low_part[8:0], 1'b0};
        end
        emit.produced = 1'b1;
        emit.word     = nxt.low_part;
        emit.kind     = hrcp_pkg::KIND_COUNT;
      end
      hrcp_pkg::POS_ADDR_0: nxt.low_part = nib_sh4;
      hrcp_pkg::POS_ADDR_1: begin
        sum          = cur.low_part + nib16;
        nxt.low_part = {sum[7:0], 8'd0};
      end
      hrcp_pkg::POS_ADDR_2: nxt.low_part = cur.low_part + nib_sh4;
      hrcp_pkg::POS_ADDR_3: begin
        nxt.low_part  = cur.low_part + nib16;
        emit.produced = 1'b1;
        emit.word     = nxt.low_part;
        emit.kind     = hrcp_pkg::KIND_ADDR;
      end
      default: ;
    endcase

    if (pos > hrcp_pkg::POS_HDR_LAST && pos < cur.line_length) begin
      unique case (pos[1:0])
        hrcp_pkg::DPH_LO_HI: nxt.low_part = nib_sh4;
        hrcp_pkg::DPH_LO_LO: nxt.low_part = cur.low_part + nib16;
        hrcp_pkg::DPH_HI_HI: nxt.high_part = nib_sh4;
        hrcp_pkg::DPH_HI_LO: begin
          sum                 = cur.high_part + nib16;
          nxt.high_part       = {sum[7:0], 8'd0};
          nxt.low_part        = cur.low_part + nxt.high_part;
          nxt.data_word_count = cur.data_word_count + 16'd1;
          emit.produced       = 1'b1;
          emit.word           = nxt.low_part;
          emit.kind           = hrcp_pkg::KIND_DATA;
        end
      endcase
    end

    if (pos < hrcp_pkg::POS_MAX) begin
      nxt.line_position = pos + 10'd1;
    end else begin
      nxt.line_position = pos;
    end

    emit.count = nxt.data_word_count;

    // restart touches only the word count here, slot pointer lives above
    if (op) begin
      nxt                 = cur;
      nxt.data_word_count = '0;
      emit                = '0;
    end
  end

endmodule

/* rtl/hex_record_char_parser.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hex_record_char_parser
// Decodes a hex record text stream one character per word into byte counts,
// load addresses and little-endian 16-bit data words tagged with ring slots.
// ----------------------------------------------------------------------------
//  channel  handshake            payload
//  in       in_valid / in_ready  op, rx_char
//  out      out_valid/ out_ready word, word_kind, ring_slot, data_words_total
//
// one character is decoded in the cycle it is taken; its word, if any, sits
// in the output register from the next cycle on. a new character is taken
// every cycle as long as the output register is empty or being drained.
// synchronous reset clears line state, slot pointer and output valid.
// ----------------------------------------------------------------------------
module hex_record_char_parser #(
  parameter int RING_SLOTS = hrcp_pkg::RING_SLOTS_DEFAULT,
  localparam int SLOT_W    = $clog2(RING_SLOTS)
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              op,
  input  logic [7:0]        rx_char,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [15:0]       word,
  output logic [1:0]        word_kind,
  output logic [SLOT_W-1:0] ring_slot,
  output logic [15:0]       data_words_total
);

  hrcp_pkg::line_state_t line_state;
  hrcp_pkg::line_state_t line_state_next;
  hrcp_pkg::emit_t       emit;
  hrcp_pkg::word_kind_t  kind;
  logic [SLOT_W-1:0]     slot_pointer;
  logic [SLOT_W-1:0]     slot_pointer_next;
  logic                  accept;

  hrcp_decode u_decode (
    .op      (op),
    .rx_char (rx_char),
    .cur     (line_state),
    .nxt     (line_state_next),
    .emit    (emit)
  );

  assign in_ready  = !out_valid || out_ready;
  assign accept    = in_valid && in_ready;
  assign word_kind = kind;

  always_comb begin
    if (slot_pointer == SLOT_W'(RING_SLOTS - 1)) begin
      slot_pointer_next = '0;
    end else begin
      slot_pointer_next = slot_pointer + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      line_state   <= '0;
      slot_pointer <= '0;
      out_valid    <= 1'b0;
    end else begin
      if (accept && emit.produced) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (accept) begin
        line_state <= line_state_next;
        if (op) begin
          slot_pointer <= '0;
        end else if (emit.produced) begin
          slot_pointer <= slot_pointer_next;
        end
      end
    end
  end

  // output payload
  always_ff @(posedge clk) begin
    if (accept && emit.produced) begin
      word             <= emit.word;
      kind             <= emit.kind;
      ring_slot        <= slot_pointer;
      data_words_total <= emit.count;
    end
  end

endmodule
